// ----- src/ewtc_pkg.sv -----
// ----------------------------------------------------------------------------
// ewtc_pkg
// Shared types, constants and clipping helpers for the weighted trapezoid
// convolution block.
// ----------------------------------------------------------------------------
package ewtc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_WIDTH = 48;

  typedef struct packed {
    logic               start_of_series;
    logic signed [31:0] curvature;
    logic signed [31:0] position;
    logic        [30:0] spacing;
  } in_t;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] integral;
    logic                        saturated;
  } out_t;

  typedef struct packed {
    logic        go;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               sat;
  } s64sat_t;

  localparam logic signed [63:0] I64_MAX  = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] X_HI     = 64'sh0000_0017_0000_0000;
  localparam logic signed [63:0] X_LO     = 64'shffff_ffe8_0000_0000;
  localparam logic signed [63:0] Z_OFS    = 64'sh0000_0018_0000_0000;
  localparam logic signed [63:0] T_OFS    = 64'sd148711873536;
  localparam logic        [63:0] LOG2E_Q25 = 64'd48408813;
  localparam logic        [63:0] LN2_Q30   = 64'd744261118;
  localparam logic        [31:0] Q30_ONE   = 32'h4000_0000;
  localparam logic [ACC_WIDTH-1:0] W_SAT   = '1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // floor(2^32 / n)
  function automatic logic [31:0] recip(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic s64sat_t sat_add64(input logic signed [63:0] a,
                                        input logic signed [63:0] b);
    logic signed [64:0] s;
    s64sat_t r;
    s = {a[63], a} + {b[63], b};
    r.sat = 1'b0;
    r.val = s[63:0];
    if (s > $signed({I64_MAX[63], I64_MAX})) begin
      r.val = I64_MAX;
      r.sat = 1'b1;
    end else if (s < -$signed({I64_MAX[63], I64_MAX})) begin
      r.val = -I64_MAX;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // magnitude product shifted right, sign applied, clipped to +-(2^63-1)
  function automatic s64sat_t mul_clip(input logic [127:0] prod,
                                       input logic half, input logic neg);
    logic [127:0] sh;
    s64sat_t r;
    sh = half ? (prod >> (FRAC_BITS + 1)) : (prod >> FRAC_BITS);
    r.sat = 1'b0;
    if (|sh[127:63]) begin
      r.sat = 1'b1;
      r.val = neg ? -I64_MAX : I64_MAX;
    end else begin
      r.val = neg ? -$signed(sh[63:0]) : $signed(sh[63:0]);
    end
    return r;
  endfunction

endpackage

// ----- src/ewtc_lmul.sv -----
// ----------------------------------------------------------------------------
// ewtc_lmul
// 64 x 64 unsigned multiplier built from one 32 x 32 unit, one partial
// product a cycle; zero upper halves are skipped.
// ----------------------------------------------------------------------------
module ewtc_lmul import ewtc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0]  a_r, b_r;
  logic [1:0]   idx_r, last_r;
  logic         busy_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_sh_r;
  logic         pp_v_r, pp_last_r, done_r;
  logic [127:0] acc_r;

  logic [31:0]  a_sel, b_sel;
  logic         need;
  logic [63:0]  pp;

  assign a_sel = idx_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_sel = idx_r[0] ? b_r[63:32] : b_r[31:0];
  assign need  = (~idx_r[1] | (|a_r[63:32])) & (~idx_r[0] | (|b_r[63:32]));
  assign pp    = {32'b0, a_sel} * {32'b0, b_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pp_v_r    <= 1'b0;
      pp_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      done_r    <= pp_last_r;
      pp_last_r <= busy_r && (idx_r == last_r);
      pp_v_r    <= busy_r && need;
      if (req.go) begin
        busy_r <= 1'b1;
      end else if (busy_r && idx_r == last_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r    <= pp;
    pp_sh_r <= {1'b0, idx_r[1]} + {1'b0, idx_r[0]};
    if (req.go) begin
      a_r    <= req.a;
      b_r    <= req.b;
      idx_r  <= 2'd0;
      last_r <= {|req.a[63:32], |req.b[63:32]};
      acc_r  <= '0;
    end else begin
      if (busy_r) begin
        idx_r <= idx_r + 2'd1;
      end
      if (pp_v_r) begin
        acc_r <= acc_r + ({64'b0, pp_r} << {pp_sh_r, 5'b0});
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ----- src/exp_weighted_trapezoid_convolution.sv -----
// ----------------------------------------------------------------------------
// exp_weighted_trapezoid_convolution
// A start-of-series word goes straight to the output; other words run the
// exponential series (skipped when the weight clips or underflows) and the
// weighted products, all sharing one 32 x 32 multiplier. One word in flight;
// the next word is taken once the result is presented, and a new result
// waits while the previous result is still unaccepted.
// Synchronous reset clears decay rate, history, accumulator and handshake state.
// ----------------------------------------------------------------------------
module exp_weighted_trapezoid_convolution import ewtc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_X, S_LOG, S_LN, S_HP, S_HD, S_HC, S_HW, S_W, S_T1, S_CW, S_T2, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic signed [31:0] decay_rate_r, prev_c_r, prev_c_nxt, prev_pos_r, prev_pos_nxt;
  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt, res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;
  in_t         in_r, in_nxt;
  logic        sat_r, sat_nxt, neg_r, neg_nxt;
  logic        mul_go_r, mul_go_nxt;
  logic [63:0] mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic signed [7:0] k_r, k_nxt;
  logic [29:0] u_r, u_nxt;
  logic [31:0] p_r, p_nxt, q_r, q_nxt, qa_r, qa_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [ACC_WIDTH-1:0] w_r, w_nxt;
  logic signed [63:0] t1_r, t1_nxt;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  assign mreq.go = mul_go_r;
  assign mreq.a  = mul_a_r;
  assign mreq.b  = mul_b_r;

  ewtc_lmul u_lmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_comb begin
    logic signed [32:0] d_v;
    logic signed [63:0] x_v, t_v, a_v;
    logic signed [7:0]  s_v, ns_v;
    logic [31:0]        r_v, quot_v;
    logic [35:0]        qn_v;
    logic [31:0]        q_v;
    s64sat_t            m_v, s_sum;

    d_v    = '0;
    x_v    = '0;
    t_v    = '0;
    a_v    = '0;
    s_v    = '0;
    ns_v   = '0;
    r_v    = '0;
    quot_v = '0;
    qn_v   = '0;
    q_v    = '0;
    m_v    = '0;
    s_sum  = '0;

    state_nxt     = state_r;
    prev_c_nxt    = prev_c_r;
    prev_pos_nxt  = prev_pos_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_nxt        = in_r;
    sat_nxt       = sat_r;
    neg_nxt       = neg_r;
    mul_go_nxt    = 1'b0;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    k_nxt         = k_r;
    u_nxt         = u_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    qa_nxt        = qa_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    t1_nxt        = t1_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt  = in_data;
          sat_nxt = 1'b0;
          if (in_data.start_of_series) begin
            res_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            d_v        = {in_data.position[31], in_data.position}
                       - {prev_pos_r[31], prev_pos_r};
            mul_a_nxt  = abs64({{32{decay_rate_r[31]}}, decay_rate_r});
            mul_b_nxt  = abs64({{31{d_v[32]}}, d_v});
            neg_nxt    = decay_rate_r[31] ^ d_v[32];
            mul_go_nxt = 1'b1;
            state_nxt  = S_X;
          end
        end
      end
      S_X: begin
        if (mrsp.done) begin
          x_v = neg_r ? -$signed(mrsp.prod[63:0]) : $signed(mrsp.prod[63:0]);
          if (x_v >= X_HI) begin
            w_nxt     = W_SAT;
            sat_nxt   = 1'b1;
            state_nxt = S_W;
          end else if (x_v < X_LO) begin
            w_nxt     = '0;
            state_nxt = S_W;
          end else begin
            mul_a_nxt  = 64'(x_v + Z_OFS);
            mul_b_nxt  = LOG2E_Q25;
            mul_go_nxt = 1'b1;
            state_nxt  = S_LOG;
          end
        end
      end
      S_LOG: begin
        if (mrsp.done) begin
          t_v   = $signed({25'b0, mrsp.prod[63:25]}) - T_OFS;
          k_nxt = t_v[39:32];
          if ($signed(t_v[39:32]) >= 8'sd32) begin
            w_nxt     = W_SAT;
            sat_nxt   = 1'b1;
            state_nxt = S_W;
          end else begin
            mul_a_nxt  = {32'b0, t_v[31:0]};
            mul_b_nxt  = LN2_Q30;
            mul_go_nxt = 1'b1;
            state_nxt  = S_LN;
          end
        end
      end
      S_LN: begin
        if (mrsp.done) begin
          u_nxt      = mrsp.prod[61:32];
          p_nxt      = Q30_ONE;
          n_nxt      = 4'd10;
          mul_a_nxt  = {32'b0, Q30_ONE};
          mul_b_nxt  = {34'b0, mrsp.prod[61:32]};
          mul_go_nxt = 1'b1;
          state_nxt  = S_HP;
        end
      end
      S_HP: begin
        if (mrsp.done) begin
          q_v = mrsp.prod[61:30];
          if (n_r == 4'd1) begin
            p_nxt     = Q30_ONE + q_v;
            state_nxt = S_HW;
          end else begin
            q_nxt      = q_v;
            mul_a_nxt  = {32'b0, q_v};
            mul_b_nxt  = {32'b0, recip(n_r)};
            mul_go_nxt = 1'b1;
            state_nxt  = S_HD;
          end
        end
      end
      S_HD: begin
        if (mrsp.done) begin
          qa_nxt    = mrsp.prod[63:32];
          state_nxt = S_HC;
        end
      end
      S_HC: begin
        qn_v       = {4'b0, qa_r} * {32'b0, n_r};
        r_v        = q_r - qn_v[31:0];
        quot_v     = (r_v >= {28'b0, n_r}) ? qa_r + 32'd1 : qa_r;
        p_nxt      = Q30_ONE + quot_v;
        n_nxt      = n_r - 4'd1;
        mul_a_nxt  = {32'b0, Q30_ONE + quot_v};
        mul_b_nxt  = {34'b0, u_r};
        mul_go_nxt = 1'b1;
        state_nxt  = S_HP;
      end
      S_HW: begin
        s_v  = k_r - 8'sd14;
        ns_v = -s_v;
        if (!s_v[7]) begin
          w_nxt = ACC_WIDTH'({32'b0, p_r} << s_v[4:0]);
        end else begin
          w_nxt = ACC_WIDTH'({32'b0, p_r} >> ns_v[5:0]);
        end
        state_nxt = S_W;
      end
      S_W: begin
        mul_a_nxt  = abs64({{(64-ACC_WIDTH){acc_r[ACC_WIDTH-1]}}, acc_r});
        mul_b_nxt  = {{(64-ACC_WIDTH){1'b0}}, w_r};
        neg_nxt    = acc_r[ACC_WIDTH-1];
        mul_go_nxt = 1'b1;
        state_nxt  = S_T1;
      end
      S_T1: begin
        if (mrsp.done) begin
          m_v        = mul_clip(mrsp.prod, 1'b0, neg_r);
          t1_nxt     = m_v.val;
          sat_nxt    = sat_r | m_v.sat;
          mul_a_nxt  = abs64({{32{prev_c_r[31]}}, prev_c_r});
          mul_b_nxt  = {{(64-ACC_WIDTH){1'b0}}, w_r};
          neg_nxt    = prev_c_r[31];
          mul_go_nxt = 1'b1;
          state_nxt  = S_CW;
        end
      end
      S_CW: begin
        if (mrsp.done) begin
          m_v        = mul_clip(mrsp.prod, 1'b0, neg_r);
          s_sum      = sat_add64(m_v.val, {{32{in_r.curvature[31]}}, in_r.curvature});
          sat_nxt    = sat_r | m_v.sat | s_sum.sat;
          mul_a_nxt  = abs64(s_sum.val);
          mul_b_nxt  = {33'b0, in_r.spacing};
          neg_nxt    = s_sum.val[63];
          mul_go_nxt = 1'b1;
          state_nxt  = S_T2;
        end
      end
      S_T2: begin
        if (mrsp.done) begin
          m_v   = mul_clip(mrsp.prod, 1'b1, neg_r);
          s_sum = sat_add64(t1_r, m_v.val);
          a_v   = s_sum.val;
          sat_nxt = sat_r | m_v.sat | s_sum.sat;
          if (a_v > $signed({{(64-ACC_WIDTH){ACC_MAX[ACC_WIDTH-1]}}, ACC_MAX})) begin
            res_nxt = ACC_MAX;
            sat_nxt = 1'b1;
          end else if (a_v < $signed({{(64-ACC_WIDTH){ACC_MIN[ACC_WIDTH-1]}}, ACC_MIN})) begin
            res_nxt = ACC_MIN;
            sat_nxt = 1'b1;
          end else begin
            res_nxt = a_v[ACC_WIDTH-1:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.integral = res_r;
          out_data_nxt.saturated = sat_r;
          acc_nxt               = res_r;
          prev_c_nxt            = in_r.curvature;
          prev_pos_nxt          = in_r.position;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      decay_rate_r <= '0;
      prev_c_r     <= '0;
      prev_pos_r   <= '0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
      mul_go_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_c_r     <= prev_c_nxt;
      prev_pos_r   <= prev_pos_nxt;
      acc_r        <= acc_nxt;
      out_valid_r  <= out_valid_nxt;
      mul_go_r     <= mul_go_nxt;
      if (cfg_we) begin
        decay_rate_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    in_r       <= in_nxt;
    res_r      <= res_nxt;
    sat_r      <= sat_nxt;
    neg_r      <= neg_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    k_r        <= k_nxt;
    u_r        <= u_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    qa_r       <= qa_nxt;
    n_r        <= n_nxt;
    w_r        <= w_nxt;
    t1_r       <= t1_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the weighted trapezoid convolution block against a behavioural
// predictor. A directed table covers field extremes, series starts, decay
// clipping and accumulator saturation; random series with bursty input and
// output stalls follow, under several decay rates including the extremes.
// ----------------------------------------------------------------------------
module tb_top import ewtc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint I64MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam int     LIMIT  = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  exp_weighted_trapezoid_convolution dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint lam, c_prev, s_prev, acc;
  out_t   pending[$];
  int     errors, words_in, words_out, cycles, sat_seen;

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint add_clip(longint a, longint b, ref bit sat);
    if (b > 0 && a > I64MAX - b) begin sat = 1; return I64MAX; end
    if (b < 0 && a < -I64MAX - b) begin sat = 1; return -I64MAX; end
    return a + b;
  endfunction

  function automatic longint scale_clip(longint a, logic [63:0] b, int sh, ref bit sat);
    logic [127:0] p;
    logic [63:0]  m;
    m = a < 0 ? 64'(-a) : 64'(a);
    p = (128'(m) * 128'(b)) >> sh;
    if (|p[127:63]) begin sat = 1; return a < 0 ? -I64MAX : I64MAX; end
    return a < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] decay_weight(longint x, ref bit sat);
    logic [63:0] wsat, f, u, p;
    longint xf, z, t, k;
    int s;
    wsat = (64'd1 << (32 + FRAC_BITS)) - 1;
    xf = asr(x, FRAC_BITS);
    if (xf >= (64'sd23 <<< FRAC_BITS)) begin sat = 1; return wsat; end
    if (xf < -(64'sd24 <<< FRAC_BITS)) return 0;
    z = x;
    t = asr(z * 48408813, 25);
    k = asr(t, 32);
    if (k >= 32) begin sat = 1; return wsat; end
    f = 64'(t - k * (64'sd1 <<< 32));
    u = (f * 64'd744261118) >> 32;
    p = 64'd1 << 30;
    for (int n = 10; n >= 1; n--) p = (64'd1 << 30) + ((p * u) >> 30) / n;
    s = int'(k) + FRAC_BITS - 30;
    if (s >= 0) return p << s;
    if (-s < 64) return p >> (-s);
    return 0;
  endfunction

  function automatic out_t integrate(in_t w);
    out_t r;
    bit sat;
    longint c, x, t1, cw, sm, t2, a;
    logic [63:0] wt;
    sat = 0;
    c = w.curvature;
    if (w.start_of_series) acc = 0;
    else begin
      x = lam * (longint'(w.position) - s_prev);
      wt = decay_weight(x, sat);
      t1 = scale_clip(acc, wt, FRAC_BITS, sat);
      cw = scale_clip(c_prev, wt, FRAC_BITS, sat);
      sm = add_clip(cw, c, sat);
      t2 = scale_clip(sm, 64'(w.spacing), FRAC_BITS + 1, sat);
      a = add_clip(t1, t2, sat);
      if (a > longint'(ACC_MAX)) begin a = ACC_MAX; sat = 1; end
      if (a < longint'(ACC_MIN)) begin a = ACC_MIN; sat = 1; end
      acc = a;
    end
    c_prev = c;
    s_prev = w.position;
    r.integral = acc[ACC_WIDTH-1:0];
    r.saturated = sat;
    return r;
  endfunction

  // receiver: stall pattern, checker
  logic [7:0] stall_pat = 8'b1011_0010;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      words_out <= words_out + 1;
      if (pending.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: expected no word, got %h", $time, out_data);
      end else begin
        if (pending[0] !== out_data) begin
          errors <= errors + 1;
          $display("%0t: expected integral %h sat %b, got integral %h sat %b", $time,
                   pending[0].integral, pending[0].saturated,
                   out_data.integral, out_data.saturated);
        end
        if (pending[0].saturated) sat_seen <= sat_seen + 1;
        void'(pending.pop_front());
      end
    end
    if (cycles % 3000 < 400) out_ready <= 1'b1;
    else begin
      stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5] ^ ($urandom_range(0, 7) == 0)};
      out_ready <= stall_pat[0] | ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    if (0) ;
    forever begin
      @(posedge clk);
      if (cycles > LIMIT) begin
        $display("%0t: timeout", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send(in_t w, bit chk, out_t want);
    out_t got;
    got = integrate(w);
    if (chk && got !== want) begin
      errors++;
      $display("%0t: table row expected %h, predictor %h", $time, want, got);
    end
    pending.push_back(got);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    words_in++;
  endtask

  task automatic gap();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic set_decay(logic [31:0] v);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lam = longint'($signed(v));
  endtask

  typedef struct { in_t w; bit chk; out_t want; } row_t;

  function automatic in_t mk(bit st, logic [31:0] c, logic [31:0] p, logic [30:0] d);
    in_t w;
    w.start_of_series = st; w.curvature = c; w.position = p; w.spacing = d;
    return w;
  endfunction

  function automatic in_t rnd_word(bit st, bit wild);
    logic [31:0] c, p;
    logic [30:0] d;
    c = wild ? $urandom : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    p = wild ? $urandom : 32'(s_prev + $urandom_range(0, 1 << 17) - (1 << 14));
    d = wild ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
    return mk(st, c, p, d);
  endfunction

  initial begin
    row_t tbl[$];
    logic [31:0] rates[8];
    int burst, len, j;
    errors = 0; words_in = 0; words_out = 0; cycles = 0; sat_seen = 0;
    lam = 0; c_prev = 0; s_prev = 0; acc = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decay 0: w = 1, plain trapezoid
    tbl.push_back('{mk(0, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000), 1, '{48'h8000, 1'b0}});
    tbl.push_back('{mk(1, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff), 1, '{48'h0, 1'b0}});
    tbl.push_back('{mk(0, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff), 0, '0});
    tbl.push_back('{mk(0, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff), 0, '0});
    tbl.push_back('{mk(0, 32'h8000_0000, 32'h0, 31'h7fff_ffff), 0, '0});
    tbl.push_back('{mk(0, 32'h8000_0000, 32'h0, 31'h7fff_ffff), 0, '0});
    tbl.push_back('{mk(1, 32'h0, 32'h0, 31'h0), 1, '{48'h0, 1'b0}});
    tbl.push_back('{mk(0, 32'h0, 32'h0, 31'h0), 1, '{48'h0, 1'b0}});
    foreach (tbl[i]) send(tbl[i].w, tbl[i].chk, tbl[i].want);

    // decay at the extremes: clipping and underflow of the weight
    set_decay(32'h7fff_ffff);
    send(mk(1, 32'h0001_0000, 32'h0, 31'h0), 1, '{48'h0, 1'b0});
    send(mk(0, 32'h0001_0000, 32'h7fff_ffff, 31'h0001_0000), 0, '0);
    send(mk(0, 32'hffff_0000, 32'h8000_0000, 31'h0001_0000), 0, '0);
    send(mk(0, 32'h5555_aaaa, 32'h8000_0001, 31'h5555_5555), 0, '0);
    set_decay(32'h8000_0000);
    send(mk(1, 32'h0001_0000, 32'h0, 31'h0), 1, '{48'h0, 1'b0});
    send(mk(0, 32'h0001_0000, 32'h7fff_ffff, 31'h0002_0000), 0, '0);
    send(mk(0, 32'haaaa_5555, 32'h0, 31'h2aaa_aaaa), 0, '0);
    send(mk(0, 32'h0001_0000, 32'h0000_0001, 31'h0001_0000), 0, '0);
    send(mk(0, 32'h0001_0000, 32'h0000_0001, 31'h0000_0000), 0, '0);

    rates = '{32'h0, 32'hffff_8000, 32'h0000_4000, 32'hfffe_0000,
              32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_fff0};
    for (int ph = 0; ph < 8; ph++) begin
      set_decay(rates[ph]);
      j = 0;
      while (j < 170) begin
        burst = $urandom_range(1, 12);
        len = $urandom_range(2, 25);
        repeat (burst) begin
          send(rnd_word((j % len) == 0 || $urandom_range(0, 40) == 0,
                        $urandom_range(0, 9) == 0), 0, '0);
          j++;
        end
        gap();
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d saturated, 8 decay settings",
             words_in, words_out, sat_seen);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
